// File: hw/rtl/tks_pkg.sv
package tks_pkg;

  // Default sizes of the node pool and of the per-node link table
  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 64;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Key status codes
  localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STS_ABSENT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CHAR  = 8'd1;

  // Configuration reset values
  localparam logic [CHAR_W-1:0] FIRST_CHAR_RST = 8'd32;
  localparam logic [CHAR_W-1:0] LAST_CHAR_RST  = 8'd95;

endpackage

// File: hw/rtl/tks_in_if.sv
interface tks_in_if import tks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [CHAR_W-1:0]   key_char;
  logic [VALUE_W-1:0]  value_in;

  modport source (output valid, func, key_char, value_in, input ready);
  modport sink   (input valid, func, key_char, value_in, output ready);
endinterface

// File: hw/rtl/tks_out_if.sv
interface tks_out_if import tks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                key_done;
  logic                found;
  logic [VALUE_W-1:0]  value_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  nodes_in_use;

  modport source (output valid, key_done, found, value_out, status, nodes_in_use,
                  input ready);
  modport sink   (input valid, key_done, found, value_out, status, nodes_in_use,
                  output ready);
endinterface

// File: hw/rtl/tks_cfg_if.sv
interface tks_cfg_if import tks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/trie_key_store_core.sv
// Character-at-a-time trie key store. Each input word carries one key
// character; character 0 ends the key, where an insert stores value_in and a
// lookup returns the stored value. Every input word yields exactly one result
// word. The accept cycle issues the reads of the child-link RAM and the
// node-value RAM, and the execute state that follows uses the read data,
// writes back an allocated link or a stored value and loads the output
// register. While a result waits in the output register the next word is still
// taken; the block stalls only when a second result is ready before the first
// is taken. After reset a clearing pass zeroes both RAMs, one entry a cycle,
// over all 2**($clog2(NODES) + $clog2(ALPHABET)) link addresses (65536 by
// default); no input word is taken during that pass, configuration writes are.
module trie_key_store_core import tks_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tks_in_if.sink    in_if,
  tks_out_if.source out_if,
  tks_cfg_if.sink   cfg_if
);

  localparam int NB  = $clog2(NODES);
  localparam int SB  = $clog2(ALPHABET);
  localparam int LAB = NB + SB;
  localparam int LDEPTH = 1 << LAB;
  localparam int CW  = $clog2(NODES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [LAB-1:0]      clr_r, clr_nxt;
  logic [CHAR_W-1:0]   first_r, first_nxt;
  logic [CHAR_W-1:0]   last_r, last_nxt;
  logic [NB-1:0]       cursor_r, cursor_nxt;
  logic                skip_r, skip_nxt;
  logic [STATUS_W-1:0] kst_r, kst_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  // Captured input word
  logic                func_r;
  logic                term_r;
  logic                inrange_r;
  logic [SB-1:0]       off_r;
  logic [VALUE_W-1:0]  val_r;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                done_r;
  logic                found_r;
  logic [VALUE_W-1:0]  vout_r;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  nodes_r;

  // RAM ports
  logic                link_we, val_we;
  logic [LAB-1:0]      link_waddr, link_raddr;
  logic [NB-1:0]       link_wdata, link_rdata;
  logic [NB-1:0]       val_waddr;
  logic [VALUE_W-1:0]  val_wdata, val_rdata;
  logic                rd_en;

  // Accept-side decode
  logic                accept;
  logic [CHAR_W:0]     diff;
  logic                inrange;
  logic [SB-1:0]       off;

  // Execute-side results
  logic                fire;
  logic                alloc;
  logic                store;
  logic                res_found;
  logic [VALUE_W-1:0]  res_val;
  logic [STATUS_W-1:0] res_status;
  logic [CW+COUNT_W-1:0] count_ext;
  logic                clearing;
  logic                clr_val_hit;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  // Range check and link slot of the incoming character
  assign diff = {1'b0, in_if.key_char} - {1'b0, first_r};
  assign inrange = (in_if.key_char >= first_r) && (in_if.key_char <= last_r) &&
                   (diff < (CHAR_W+1)'(ALPHABET));
  assign off = diff[SB-1:0];

  assign rd_en = accept;
  assign link_raddr = {cursor_r, off};

  // Execute when the output register can take the result
  assign fire = (state_r == ST_EXEC) && (!out_valid_r || out_if.ready);

  always_comb begin
    cursor_nxt = cursor_r;
    skip_nxt   = skip_r;
    kst_nxt    = kst_r;
    count_nxt  = count_r;
    alloc      = 1'b0;
    store      = 1'b0;
    res_found  = 1'b0;
    res_val    = '0;
    res_status = kst_r;
    if (term_r) begin
      // Terminator: store or report, then return to the root
      if (!skip_r) begin
        if (func_r == FUNC_LOOKUP) begin
          if (val_rdata != '0) begin
            res_found = 1'b1;
            res_val   = val_rdata;
          end else begin
            res_status = STS_ABSENT;
          end
        end else begin
          store = 1'b1;
        end
      end
      cursor_nxt = '0;
      skip_nxt   = 1'b0;
      kst_nxt    = STS_OK;
    end else begin
      // Character: follow or allocate a child link
      if (!skip_r) begin
        if (!inrange_r) begin
          kst_nxt  = STS_RANGE;
          skip_nxt = 1'b1;
        end else if (link_rdata != '0) begin
          cursor_nxt = link_rdata;
        end else if (func_r == FUNC_LOOKUP) begin
          kst_nxt  = STS_ABSENT;
          skip_nxt = 1'b1;
        end else if (count_r >= CW'(NODES)) begin
          kst_nxt  = STS_FULL;
          skip_nxt = 1'b1;
        end else begin
          alloc      = 1'b1;
          cursor_nxt = count_r[NB-1:0];
          count_nxt  = count_r + CW'(1);
        end
      end
      res_status = kst_nxt;
    end
  end

  // Clearing pass drives the write ports until it ends
  assign clearing = (state_r == ST_CLEAR);
  assign clr_val_hit = (clr_r[LAB-1:NB] == '0) &&
                       ({1'b0, clr_r[NB-1:0]} < (NB+1)'(NODES));

  assign link_we    = clearing || (fire && alloc);
  assign link_waddr = clearing ? clr_r : {cursor_r, off_r};
  assign link_wdata = clearing ? '0 : count_r[NB-1:0];
  assign val_we     = clearing ? clr_val_hit : (fire && store);
  assign val_waddr  = clearing ? clr_r[NB-1:0] : cursor_r;
  assign val_wdata  = clearing ? '0 : val_r;

  tks_ram #(
    .WIDTH (NB),
    .DEPTH (LDEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (rd_en),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  tks_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NODES)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_wdata),
    .rd_en   (rd_en),
    .rd_addr (cursor_r),
    .rd_data (val_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + LAB'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Configuration writes; unknown indexes drop
  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index == REG_FIRST_CHAR) begin
        first_nxt = cfg_if.data;
      end else if (cfg_if.index == REG_LAST_CHAR) begin
        last_nxt = cfg_if.data;
      end
    end
  end

  // Output word: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      first_r     <= FIRST_CHAR_RST;
      last_r      <= LAST_CHAR_RST;
      cursor_r    <= '0;
      skip_r      <= 1'b0;
      kst_r       <= STS_OK;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        cursor_r <= cursor_nxt;
        skip_r   <= skip_nxt;
        kst_r    <= kst_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // Capture the accepted word and load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_if.func;
      term_r    <= (in_if.key_char == '0);
      inrange_r <= inrange;
      off_r     <= off;
      val_r     <= in_if.value_in;
    end
    if (fire) begin
      done_r   <= term_r;
      found_r  <= res_found;
      vout_r   <= res_val;
      status_r <= res_status;
      nodes_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.key_done     = done_r;
  assign out_if.found        = found_r;
  assign out_if.value_out    = vout_r;
  assign out_if.status       = status_r;
  assign out_if.nodes_in_use = nodes_r;

  // Pool count never passes the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NODES))
    else $error("node count beyond pool size");

  // An allocation adds exactly one node
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && alloc) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("allocation did not advance node count");

  // A skipped key always carries an error status
  a_skip_status: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (kst_r != STS_OK))
    else $error("skip set with ok status");

  // An accepted word puts the sequencer in the execute state in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted word not executed");

endmodule

// File: hw/rtl/tks_ram.sv
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sim/trie_key_store_core_tb.sv
module trie_key_store_core_tb;
  import tks_pkg::*;

  localparam int NODES    = NODES_DEF;
  localparam int ALPHA    = ALPHABET_DEF;
  localparam int NODE_W   = $clog2(NODES);
  localparam int LIMIT    = 1000000;
  localparam int BANK     = 48;
  localparam int MAXLEN   = 8;
  localparam int FILL_LEN = 16;
  localparam int PHASES   = 8;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic               func;
    logic [CHAR_W-1:0]  ch;
    logic [VALUE_W-1:0] val;
  } key_word_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  nodes;
  } result_word_t;

  logic clk;
  logic rst_n;

  tks_in_if  in_ch ();
  tks_out_if out_ch ();
  tks_cfg_if cfg_ch ();

  trie_key_store_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow trie state
  logic [CHAR_W-1:0]   cfg_first;
  logic [CHAR_W-1:0]   cfg_last;
  logic [NODE_W-1:0]   walk_node;
  bit                  walk_skip;
  logic [STATUS_W-1:0] walk_status;
  int                  pool_used;
  logic [NODE_W-1:0]   link_mem [0:NODES*ALPHA-1];
  logic [VALUE_W-1:0]  val_mem  [0:NODES-1];

  // Pending input words and expected results
  key_word_t    word_q [$];
  result_word_t result_q [$];

  // Stored keys for replayed lookups
  logic [CHAR_W-1:0] bank_chars [0:BANK-1][0:MAXLEN-1];
  int                bank_len [0:BANK-1];
  int                bank_n;

  int  n_queued, n_taken, n_results, errors, cycle_cnt;
  int  lookup_hits, full_keys, settings_seen;
  int  src_idle_pct, snk_stall_pct;
  bit  in_fire, cfg_fire;
  key_word_t    drive_w;
  result_word_t got_w;
  result_word_t want_w;

  // Per-phase register settings and item counts
  int unsigned ph_first [0:PHASES-1] = '{32, 1, 97, 200, 255, 1, 40, 1};
  int unsigned ph_last  [0:PHASES-1] = '{95, 255, 122, 100, 255, 1, 255, 255};
  int          ph_items [0:PHASES-1] = '{250, 250, 250, 100, 100, 50, 200, 100};

  function automatic void trie_clear();
    foreach (link_mem[i]) link_mem[i] = '0;
    foreach (val_mem[i]) val_mem[i] = '0;
    cfg_first   = FIRST_CHAR_RST;
    cfg_last    = LAST_CHAR_RST;
    walk_node   = '0;
    walk_skip   = 1'b0;
    walk_status = STS_OK;
    pool_used   = 1;
  endfunction

  // Advance the shadow trie by one key word and return the result it yields
  function automatic result_word_t trie_step(key_word_t w);
    result_word_t r;
    int slot;
    int nxt;
    r = '0;
    if (w.ch == '0) begin
      r.done = 1'b1;
      if (!walk_skip) begin
        if (w.func == FUNC_LOOKUP) begin
          if (val_mem[walk_node] != '0) begin
            r.found = 1'b1;
            r.value = val_mem[walk_node];
          end else begin
            walk_status = STS_ABSENT;
          end
        end else begin
          val_mem[walk_node] = w.val;
        end
      end
      r.status    = walk_status;
      walk_node   = '0;
      walk_skip   = 1'b0;
      walk_status = STS_OK;
    end else begin
      if (!walk_skip) begin
        if (w.ch < cfg_first || w.ch > cfg_last ||
            int'(w.ch) - int'(cfg_first) >= ALPHA) begin
          walk_status = STS_RANGE;
          walk_skip   = 1'b1;
        end else begin
          slot = int'(walk_node) * ALPHA + (int'(w.ch) - int'(cfg_first));
          nxt  = int'(link_mem[slot]);
          if (nxt != 0) begin
            walk_node = nxt[NODE_W-1:0];
          end else if (w.func == FUNC_LOOKUP) begin
            walk_status = STS_ABSENT;
            walk_skip   = 1'b1;
          end else if (pool_used >= NODES) begin
            walk_status = STS_FULL;
            walk_skip   = 1'b1;
          end else begin
            link_mem[slot] = pool_used[NODE_W-1:0];
            walk_node      = pool_used[NODE_W-1:0];
            pool_used++;
          end
        end
      end
      r.status = walk_status;
    end
    r.nodes = pool_used[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(string what, result_word_t e, result_word_t g);
    errors++;
    if (errors <= 10) begin
      $display("[%0d] %s: expected done=%0b found=%0b value=%h status=%0d nodes=%0d",
               cycle_cnt, what, e.done, e.found, e.value, e.status, e.nodes);
      $display("[%0d] %s: got      done=%0b found=%0b value=%h status=%0d nodes=%0d",
               cycle_cnt, what, g.done, g.found, g.value, g.status, g.nodes);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: record accepted words, predict, and check results
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, result_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      in_fire  = rst_n && in_ch.valid && in_ch.ready;
      cfg_fire = rst_n && cfg_ch.valid && cfg_ch.ready;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got_w = '{out_ch.key_done, out_ch.found, out_ch.value_out, out_ch.status,
                  out_ch.nodes_in_use};
        n_results++;
        if (result_q.size() == 0) begin
          note_mismatch("unexpected result word", '0, got_w);
        end else begin
          want_w = result_q.pop_front();
          if (got_w.done !== want_w.done || got_w.found !== want_w.found ||
              got_w.value !== want_w.value || got_w.status !== want_w.status ||
              got_w.nodes !== want_w.nodes)
            note_mismatch("result mismatch", want_w, got_w);
        end
      end
      if (in_fire) begin
        want_w = trie_step(key_word_t'{in_ch.func, in_ch.key_char, in_ch.value_in});
        if (want_w.found) lookup_hits++;
        if (want_w.done && want_w.status == STS_FULL) full_keys++;
        result_q.push_back(want_w);
        n_taken++;
      end
      if (cfg_fire) begin
        if (cfg_ch.index == REG_FIRST_CHAR) cfg_first = cfg_ch.data;
        else if (cfg_ch.index == REG_LAST_CHAR) cfg_last = cfg_ch.data;
      end
    end
  end

  // Driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_w = word_q.pop_front();
        in_ch.func     <= drive_w.func;
        in_ch.key_char <= drive_w.ch;
        in_ch.value_in <= drive_w.val;
        in_ch.valid    <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(logic fn, logic [CHAR_W-1:0] c, logic [VALUE_W-1:0] v);
    word_q.push_back(key_word_t'{fn, c, v});
    n_queued++;
  endtask

  task automatic set_idle(idle_mode_t m);
    src_idle_pct  = (m == IDLE_SRC) ? 85 : (m == IDLE_BOTH) ? 21 : 0;
    snk_stall_pct = (m == IDLE_SNK) ? 85 : (m == IDLE_BOTH) ? 21 : 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
    settings_seen++;
  endtask

  // Wait until every queued word is taken and answered, then let the pipe settle
  task automatic wait_idle();
    while (n_taken != n_queued || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Queue one key: a replayed stored key, a fresh well-formed key, or noise
  task automatic gen_key();
    int mode, len, pick, lo, hi, span;
    logic fn;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] chars [0:MAXLEN-1];
    mode = $urandom_range(99);
    lo   = int'(cfg_first);
    hi   = int'(cfg_last);
    if (hi > lo + ALPHA - 1) hi = lo + ALPHA - 1;
    span = hi - lo;
    if (mode < 35 && bank_n > 0) begin
      pick = $urandom_range(bank_n - 1);
      fn   = ($urandom_range(3) != 0) ? FUNC_LOOKUP : FUNC_INSERT;
      for (int i = 0; i < bank_len[pick]; i++)
        push_word(fn, bank_chars[pick][i], {$urandom, $urandom});
      push_word(fn, '0, rand_value());
    end else if (mode < 85) begin
      len = $urandom_range(0, 6);
      fn  = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
        if (span < 0) c = CHAR_W'($urandom_range(1, 255));
        else if ($urandom_range(9) < 6)
          c = CHAR_W'(lo + $urandom_range(0, (span < 3) ? span : 3));
        else
          c = CHAR_W'($urandom_range(lo, hi));
        chars[i] = c;
        push_word(fn, c, {$urandom, $urandom});
      end
      push_word(fn, '0, rand_value());
      // keep inserted keys for later lookups
      if (fn == FUNC_INSERT) begin
        if (bank_n < BANK) begin
          pick = bank_n;
          bank_n++;
        end else begin
          pick = $urandom_range(BANK - 1);
        end
        bank_len[pick] = len;
        for (int i = 0; i < len; i++) bank_chars[pick][i] = chars[i];
      end
    end else begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        push_word(1'($urandom_range(1)), CHAR_W'($urandom_range(1, 255)),
                  {$urandom, $urandom});
      push_word(1'($urandom_range(1)), '0, rand_value());
    end
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_INSERT;
    in_ch.key_char = '0;
    in_ch.value_in = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    n_queued = 0; n_taken = 0; n_results = 0; errors = 0; cycle_cnt = 0;
    lookup_hits = 0; full_keys = 0; settings_seen = 1; bank_n = 0;
    in_fire = 1'b0; cfg_fire = 1'b0;
    trie_clear();
    set_idle(IDLE_NONE);
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed keys under the reset character range
    push_word(FUNC_INSERT, 8'd0, '1);                 // empty key stores at root
    push_word(FUNC_LOOKUP, 8'd0, '0);
    push_word(FUNC_INSERT, 8'd32, '0);                // range edges
    push_word(FUNC_INSERT, 8'd95, '0);
    push_word(FUNC_INSERT, 8'd0, 64'h1);
    push_word(FUNC_LOOKUP, 8'd32, '0);
    push_word(FUNC_LOOKUP, 8'd95, '0);
    push_word(FUNC_LOOKUP, 8'd0, '0);
    push_word(FUNC_LOOKUP, 8'd33, '0);                // absent link
    push_word(FUNC_LOOKUP, 8'd0, '0);
    push_word(FUNC_INSERT, 8'd31, '0);                // below range, rest skipped
    push_word(FUNC_INSERT, 8'd40, '0);
    push_word(FUNC_INSERT, 8'd0, 64'h5);
    push_word(FUNC_INSERT, 8'd96, '0);                // above range, mixed func
    push_word(FUNC_LOOKUP, 8'd255, '0);
    push_word(FUNC_LOOKUP, 8'd0, '0);
    push_word(FUNC_INSERT, 8'd32, '0);                // store zero clears value
    push_word(FUNC_INSERT, 8'd95, '0);
    push_word(FUNC_INSERT, 8'd0, '0);
    push_word(FUNC_LOOKUP, 8'd32, '0);
    push_word(FUNC_LOOKUP, 8'd95, '0);
    push_word(FUNC_LOOKUP, 8'd0, '0);
    push_word(FUNC_INSERT, 8'd32, '0);                // insert walk, lookup end
    push_word(FUNC_LOOKUP, 8'd0, '0);
    wait_idle();

    // Random phases, each with a character range and an idle pattern
    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        write_reg(CFG_IDX_W'(2), CFG_DATA_W'($urandom));   // unmapped indexes
        write_reg('1, CFG_DATA_W'($urandom));
      end
      write_reg(REG_FIRST_CHAR, CFG_DATA_W'(ph_first[p]));
      write_reg(REG_LAST_CHAR, CFG_DATA_W'(ph_last[p]));
      set_idle(idle_mode_t'(p % 4));
      // last phase: fill the node pool with long inserts first
      if (p == PHASES - 1) begin
        while (pool_used < NODES) begin
          repeat ((NODES - pool_used) / (FILL_LEN - 1) + 2) begin
            for (int i = 0; i < FILL_LEN; i++)
              push_word(FUNC_INSERT, CHAR_W'($urandom_range(1, ALPHA)), {$urandom, $urandom});
            push_word(FUNC_INSERT, '0, rand_value());
          end
          wait_idle();
        end
      end
      target = n_queued + ph_items[p];
      while (n_queued < target) gen_key();
      wait_idle();
    end

    $display("Checked %0d result words over %0d register settings and four idle patterns.",
             n_results, settings_seen);
    $display("Lookups found %0d stored values; %0d keys ended on a full pool of %0d nodes.",
             lookup_hits, full_keys, pool_used);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, result_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
